FILE: src/dfmt_pkg.sv
// Shared constants and types of the decimal formatter with fill.
package dfmt_pkg;

  localparam int BufChars  = 32;
  localparam int MagW      = 64;
  localparam int NumDigits = 20;
  localparam int BcdW      = NumDigits * 4;
  localparam int DigCntW   = 5;
  localparam int WidthW    = 7;
  localparam int MinWidthW = 6;
  localparam int CharW     = 8;
  localparam int StepW     = 6;

  localparam logic [StepW-1:0]   StepFirst = StepW'(MagW - 1);
  localparam logic [DigCntW-1:0] DigitsMax = DigCntW'(NumDigits);
  localparam logic [CharW-1:0]   ChZero    = 8'h30;
  localparam logic [CharW-1:0]   ChMinus   = 8'h2D;

  // Result of the binary to decimal conversion, leading zeros removed.
  typedef struct packed {
    logic [BcdW-1:0]    bcd;
    logic [DigCntW-1:0] ndig;
  } conv_res_t;

  // Formatting options captured with the item.
  typedef struct packed {
    logic                 neg;
    logic [MinWidthW-1:0] min_width;
    logic [CharW-1:0]     fill;
  } fmt_cmd_t;

endpackage

FILE: src/decimal_formatter_with_fill.sv
// The first character follows the input transfer after the shift and add 3 steps over the
// magnitude bits, the leading zero strip, the converter's done state and the output load.
// The text then leaves at one character per cycle while the sink is ready: 1 to 32 chars.
// A new item is taken only once the previous one has been converted and its last character
// loaded into the output register; in_ready_o rises when the sequencer returns to idle.
// Reset is asynchronous and active low; it clears control state and drops out_valid_o.
module decimal_formatter_with_fill
  import dfmt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [MagW-1:0]      magnitude_i,
  input  logic                 negative_i,
  input  logic [MinWidthW-1:0] min_width_i,
  input  logic [CharW-1:0]     fill_char_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CharW-1:0]     text_char_o,
  output logic                 last_o
);

  // Top level sequencer: wait for an item, run the converter, then stream characters.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } top_state_e;

  top_state_e state_q, state_d;
  fmt_cmd_t   cmd_q;
  logic       in_xfer;
  logic       conv_done;
  conv_res_t  conv_res;
  logic       emit_start;
  logic       emit_busy;

  // The block takes a new item only between items; one transfer starts the converter.
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign emit_start = (state_q == ST_CONV) && conv_done;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_xfer)    state_d = ST_CONV;
      ST_CONV: if (conv_done)  state_d = ST_EMIT;
      ST_EMIT: if (!emit_busy) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Formatting options are held for the whole item; the magnitude goes straight in.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q.neg       <= negative_i;
      cmd_q.min_width <= min_width_i;
      cmd_q.fill      <= fill_char_i;
    end
  end

  // The converter shifts one magnitude bit into the BCD register per cycle.
  dfmt_bcd_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_xfer),
    .magnitude_i (magnitude_i),
    .done_o      (conv_done),
    .res_o       (conv_res)
  );

  // The emitter places the sign before or after the fill and marks the final digit.
  dfmt_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (emit_start),
    .res_i       (conv_res),
    .cmd_i       (cmd_q),
    .busy_o      (emit_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .text_char_o (text_char_o),
    .last_o      (last_o)
  );

endmodule

FILE: src/dfmt_bcd_conv.sv
// Iterative binary to BCD converter (shift and add 3) with leading zero strip.
module dfmt_bcd_conv
  import dfmt_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [MagW-1:0] magnitude_i,
  output logic            done_o,
  output conv_res_t       res_o
);

  typedef enum logic [2:0] {
    CV_IDLE  = 3'b001,
    CV_SHIFT = 3'b010,
    CV_STRIP = 3'b100
  } cv_state_e;

  cv_state_e          state_q, state_d;
  logic [MagW-1:0]    bin_q, bin_d;
  logic [BcdW-1:0]    bcd_q, bcd_d;
  logic [StepW-1:0]   step_q, step_d;
  logic [DigCntW-1:0] ndig_q, ndig_d;
  logic [BcdW-1:0]    bcd_adj;
  logic               strip_more;

  // Add 3 to every digit that would overflow when doubled.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
                                                   : bcd_q[i*4 +: 4];
    end
  end

  assign strip_more = (bcd_q[BcdW-1 -: 4] == 4'd0) && (ndig_q > DigCntW'(1));

  always_comb begin
    state_d = state_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    step_d  = step_q;
    ndig_d  = ndig_q;
    done_o  = 1'b0;
    unique case (state_q)
      CV_IDLE: begin
        if (start_i) begin
          bin_d   = magnitude_i;
          bcd_d   = '0;
          step_d  = StepFirst;
          ndig_d  = DigitsMax;
          state_d = CV_SHIFT;
        end
      end
      CV_SHIFT: begin
        bcd_d  = {bcd_adj[BcdW-2:0], bin_q[MagW-1]};
        bin_d  = {bin_q[MagW-2:0], 1'b0};
        step_d = step_q - StepW'(1);
        if (step_q == '0) begin
          state_d = CV_STRIP;
        end
      end
      CV_STRIP: begin
        if (strip_more) begin
          bcd_d  = {bcd_q[BcdW-5:0], 4'd0};
          ndig_d = ndig_q - DigCntW'(1);
        end else begin
          done_o  = 1'b1;
          state_d = CV_IDLE;
        end
      end
      default: state_d = CV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    step_q <= step_d;
    ndig_q <= ndig_d;
  end

  assign res_o.bcd  = bcd_q;
  assign res_o.ndig = ndig_q;

endmodule

FILE: src/dfmt_emit.sv
// Character sequencer: sign, fill and digits into a registered output stage.
module dfmt_emit
  import dfmt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  conv_res_t        res_i,
  input  fmt_cmd_t         cmd_i,
  output logic             busy_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CharW-1:0] text_char_o,
  output logic             last_o
);

  logic [BcdW-1:0]    dig_q, dig_d;
  logic [DigCntW-1:0] left_q, left_d;
  logic [WidthW-1:0]  fill_cnt_q, fill_cnt_d;
  logic               sign_pre_q, sign_pre_d;
  logic               sign_post_q, sign_post_d;
  logic [CharW-1:0]   fill_q, fill_d;
  logic               valid_q, valid_d;
  logic [CharW-1:0]   char_q, char_d;
  logic               last_q, last_d;

  logic [WidthW-1:0]  text_len;
  logic [WidthW-1:0]  width_sat;
  logic [WidthW-1:0]  fillers;
  logic               load;

  assign text_len  = WidthW'(res_i.ndig) + WidthW'(cmd_i.neg);
  assign width_sat = (WidthW'(cmd_i.min_width) > WidthW'(BufChars)) ? WidthW'(BufChars)
                                                                    : WidthW'(cmd_i.min_width);
  assign fillers   = (width_sat > text_len) ? width_sat - text_len : '0;

  assign busy_o = (left_q != '0);
  assign load   = busy_o && (!valid_q || out_ready_i);

  always_comb begin
    dig_d       = dig_q;
    left_d      = left_q;
    fill_cnt_d  = fill_cnt_q;
    sign_pre_d  = sign_pre_q;
    sign_post_d = sign_post_q;
    fill_d      = fill_q;
    valid_d     = valid_q;
    char_d      = char_q;
    last_d      = last_q;

    if (out_ready_i) begin
      valid_d = 1'b0;
    end

    if (start_i) begin
      dig_d       = res_i.bcd;
      left_d      = res_i.ndig;
      fill_cnt_d  = fillers;
      fill_d      = cmd_i.fill;
      sign_pre_d  = cmd_i.neg && (fillers != '0) && (cmd_i.fill == ChZero);
      sign_post_d = cmd_i.neg && !((fillers != '0) && (cmd_i.fill == ChZero));
    end else if (load) begin
      valid_d = 1'b1;
      last_d  = 1'b0;
      if (sign_pre_q) begin
        char_d     = ChMinus;
        sign_pre_d = 1'b0;
      end else if (fill_cnt_q != '0) begin
        char_d     = fill_q;
        fill_cnt_d = fill_cnt_q - WidthW'(1);
      end else if (sign_post_q) begin
        char_d      = ChMinus;
        sign_post_d = 1'b0;
      end else begin
        char_d = ChZero + {4'd0, dig_q[BcdW-1 -: 4]};
        dig_d  = {dig_q[BcdW-5:0], 4'd0};
        left_d = left_q - DigCntW'(1);
        last_d = (left_q == DigCntW'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      left_q  <= left_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q       <= dig_d;
    fill_cnt_q  <= fill_cnt_d;
    sign_pre_q  <= sign_pre_d;
    sign_post_q <= sign_post_d;
    fill_q      <= fill_d;
    char_q      <= char_d;
    last_q      <= last_d;
  end

  assign out_valid_o = valid_q;
  assign text_char_o = char_q;
  assign last_o      = last_q;

endmodule

FILE: src/dfmt_checker.sv
// Port level checks of the decimal formatter with fill, bound to the top level.
module dfmt_checker
  import dfmt_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [CharW-1:0]     text_char_o,
  input logic                 last_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(text_char_o) && $stable(last_o))
    else $error("output changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o || last_o)
    else $error("ready while a non-final character is pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o || last_o)
    else $error("non-final character shortly after a transfer");

endmodule

bind decimal_formatter_with_fill dfmt_checker u_dfmt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .text_char_o (text_char_o),
  .last_o      (last_o)
);

FILE: verif/tb_top.sv
// Testbench of the decimal formatter with fill: random and directed numbers, checked per character.
//
// Numbers are queued up front by the stimulus process and handed to the formatter by a
// clocked driver that works in bursts with random gaps. Each number that the formatter
// takes is turned into its expected text right away, one entry per character, and a
// clocked monitor compares every character that leaves the formatter against the oldest
// entry. The output side stalls on a pattern of its own, and twice it holds off long
// enough for the formatter to back up into its input.
module tb_top;
  import dfmt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One number to format, as it sits on the input ports.
  typedef struct packed {
    logic [MagW-1:0]      mag;
    logic                 neg;
    logic [MinWidthW-1:0] min_width;
    logic [CharW-1:0]     fill;
  } num_item_t;

  // One character of expected text.
  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             is_last;
  } text_beat_t;

  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam int ResetCycles = 9;
  localparam int HoldOffCycles = 400;
  localparam int NumRandom = 500;
  localparam int DrainCycles = 200;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [MagW-1:0]      magnitude_i = '0;
  logic                 negative_i = 1'b0;
  logic [MinWidthW-1:0] min_width_i = '0;
  logic [CharW-1:0]     fill_char_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [CharW-1:0]     text_char_o;
  logic                 last_o;

  num_item_t  pending_num_q[$];
  text_beat_t expected_text_q[$];
  num_item_t  cur_num;

  int n_errors = 0;
  int n_nums_taken = 0;
  int n_chars_seen = 0;
  int n_padded = 0;
  int n_sign_first = 0;
  int n_width_capped = 0;

  decimal_formatter_with_fill u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .magnitude_i (magnitude_i),
    .negative_i  (negative_i),
    .min_width_i (min_width_i),
    .fill_char_i (fill_char_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .text_char_o (text_char_o),
    .last_o      (last_o)
  );

  always #1 clk_i = ~clk_i;

  // Powers of ten up to 10^19, which still fit into 64 bits.
  function automatic logic [MagW-1:0] pow10(int exp10);
    logic [MagW-1:0] acc;
    acc = 64'd1;
    repeat (exp10) acc = acc * 64'd10;
    return acc;
  endfunction

  // Works out the text of one number and appends it, character by character, to the
  // expected text. Digits are peeled off least significant first and then emitted in
  // reverse. A width beyond the buffer is capped at the buffer size. The sign goes in
  // front of the padding only when there is padding and the fill is the zero digit.
  function automatic void format_expected_text(num_item_t item);
    logic [CharW-1:0] digit_chars[NumDigits];
    logic [CharW-1:0] line[$];
    logic [MagW-1:0]  rest;
    int ndig;
    int width;
    int text_len;
    int pad_len;
    rest = item.mag;
    ndig = 0;
    do begin
      digit_chars[ndig] = ChZero + CharW'(rest % 64'd10);
      rest = rest / 64'd10;
      ndig++;
    end while (rest != 0);
    width = (int'(item.min_width) > BufChars) ? BufChars : int'(item.min_width);
    text_len = ndig + int'(item.neg);
    pad_len = (width > text_len) ? width - text_len : 0;
    if (item.neg && pad_len > 0 && item.fill == ChZero) begin
      line.push_back(ChMinus);
      repeat (pad_len) line.push_back(item.fill);
      n_sign_first++;
    end else begin
      repeat (pad_len) line.push_back(item.fill);
      if (item.neg) line.push_back(ChMinus);
    end
    for (int i = ndig - 1; i >= 0; i--) line.push_back(digit_chars[i]);
    foreach (line[i]) expected_text_q.push_back('{ch: line[i], is_last: (i == line.size() - 1)});
    if (pad_len > 0) n_padded++;
    if (int'(item.min_width) > BufChars) n_width_capped++;
  endfunction

  // Driver. A number counts as taken at the edge where valid and ready are both high;
  // its expected text is produced there. A new number is presented only once the
  // previous one is gone, and valid holds with a steady payload until the transfer.
  // The sender offers bursts of random length and pauses between them; some pauses are
  // long enough to land in every phase of the conversion, some bursts have none at all.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        format_expected_text(cur_num);
        n_nums_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_num_q.size() > 0) begin
          cur_num = pending_num_q.pop_front();
          in_valid_i  <= 1'b1;
          magnitude_i <= cur_num.mag;
          negative_i  <= cur_num.neg;
          min_width_i <= cur_num.min_width;
          fill_char_i <= cur_num.fill;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 8);
            case ($urandom_range(0, 5))
              0, 1:    gap_left = 0;
              2, 3:    gap_left = $urandom_range(1, 3);
              default: gap_left = $urandom_range(4, 150);
            endcase
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver. It cycles through three moods of random duration: always ready, ready
  // half the time, and mostly stalled. Twice in the run, after a set number of numbers
  // has been taken, it refuses everything for a long stretch so that the formatter
  // fills up and has to stall its input while the driver keeps offering numbers.
  int mood = 0;
  int mood_left = 0;
  int hold_left = 0;
  int holds_done = 0;
  int hold_at[2] = '{100, 350};

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (holds_done < 2 && n_nums_taken >= hold_at[holds_done]) begin
      hold_left = HoldOffCycles;
      holds_done++;
      out_ready_i <= 1'b0;
    end else begin
      if (mood_left == 0) begin
        mood = $urandom_range(0, 2);
        mood_left = $urandom_range(64, 600);
      end else begin
        mood_left--;
      end
      case (mood)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Monitor. Every character that leaves is matched against the oldest expected one;
  // the character and the end-of-number flag are checked separately.
  always @(posedge clk_i) begin
    text_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_text_q.size() == 0) begin
        n_errors++;
        $display("%0t ERROR: character %h last %b with nothing expected",
                 $time, text_char_o, last_o);
      end else begin
        want = expected_text_q.pop_front();
        n_chars_seen++;
        if (text_char_o !== want.ch) begin
          n_errors++;
          $display("%0t ERROR: text_char expected %h actual %h", $time, want.ch, text_char_o);
        end
        if (last_o !== want.is_last) begin
          n_errors++;
          $display("%0t ERROR: last expected %b actual %b", $time, want.is_last, last_o);
        end
      end
    end
  end

  // Stimulus: directed corner numbers first, then random ones, then reset release,
  // the drain and the verdict.
  initial begin
    num_item_t item;
    int ndig;
    logic [MagW-1:0] lo;
    logic [MagW-1:0] span;
    logic [MagW-1:0] rnd;

    // Zero in all its forms, including negative zero with and without zero padding.
    pending_num_q.push_back('{64'd0, 1'b0, 6'd0, ChSpace});
    pending_num_q.push_back('{64'd0, 1'b1, 6'd0, ChSpace});
    pending_num_q.push_back('{64'd0, 1'b1, 6'd5, ChZero});
    pending_num_q.push_back('{64'd0, 1'b1, 6'd5, ChSpace});
    // The largest magnitude: twenty digits, plain, padded and at full buffer width.
    pending_num_q.push_back('{'1, 1'b1, 6'd0, ChZero});
    pending_num_q.push_back('{'1, 1'b0, 6'd32, 8'h2A});
    pending_num_q.push_back('{'1, 1'b1, 6'd32, ChZero});
    // Sign after non-zero fill, sign before zero fill.
    pending_num_q.push_back('{64'd123, 1'b1, 6'd8, ChSpace});
    pending_num_q.push_back('{64'd123, 1'b1, 6'd8, ChZero});
    pending_num_q.push_back('{64'd123, 1'b0, 6'd10, ChZero});
    // Widths beyond the buffer are capped.
    pending_num_q.push_back('{64'd123, 1'b0, 6'd63, 8'h2E});
    pending_num_q.push_back('{64'd123, 1'b1, 6'd33, ChZero});
    // Width equal to the text length adds nothing; one more adds a single fill.
    pending_num_q.push_back('{64'd12345, 1'b1, 6'd6, ChZero});
    pending_num_q.push_back('{64'd12345, 1'b1, 6'd7, ChZero});
    // Digit count transitions, up to the largest count.
    pending_num_q.push_back('{64'd9, 1'b0, 6'd0, ChSpace});
    pending_num_q.push_back('{64'd10, 1'b0, 6'd0, ChSpace});
    pending_num_q.push_back('{64'd99, 1'b1, 6'd0, ChSpace});
    pending_num_q.push_back('{64'd100, 1'b1, 6'd0, ChSpace});
    pending_num_q.push_back('{pow10(19) - 64'd1, 1'b0, 6'd0, ChSpace});
    pending_num_q.push_back('{pow10(19), 1'b0, 6'd0, ChSpace});
    // Fill values at both ends of the byte range.
    pending_num_q.push_back('{64'd7, 1'b1, 6'd4, 8'h00});
    pending_num_q.push_back('{64'd1, 1'b1, 6'd32, 8'hFF});

    for (int n = 0; n < NumRandom; n++) begin
      rnd = {$urandom(), $urandom()};
      case ($urandom_range(0, 9))
        0, 1, 2: item.mag = rnd;
        3, 4, 5, 6: begin
          // A random number with a chosen digit count.
          ndig = $urandom_range(1, NumDigits);
          lo = (ndig == 1) ? 64'd0 : pow10(ndig - 1);
          span = (ndig == NumDigits) ? ('1 - lo + 64'd1) : (pow10(ndig) - lo);
          item.mag = lo + rnd % span;
        end
        7: item.mag = pow10($urandom_range(1, 19)) + 64'($urandom_range(0, 2)) - 64'd1;
        8: item.mag = 64'($urandom_range(0, 20));
        default: item.mag = '1 - 64'($urandom_range(0, 20));
      endcase
      item.neg = 1'($urandom_range(0, 1));
      item.min_width = ($urandom_range(0, 9) < 8) ? MinWidthW'($urandom_range(0, 33))
                                                  : MinWidthW'($urandom_range(34, 63));
      case ($urandom_range(0, 9))
        0, 1, 2, 3: item.fill = ChZero;
        4, 5:       item.fill = ChSpace;
        default:    item.fill = CharW'($urandom_range(0, 255));
      endcase
      pending_num_q.push_back(item);
    end

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Every number has gone in once the queue is empty and valid has dropped.
    while (pending_num_q.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_text_q.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d numbers and %0d characters: %0d padded, %0d with the sign ahead",
             n_nums_taken, n_chars_seen, n_padded, n_sign_first);
    $display("of zero fill, %0d with the width capped at the buffer size.", n_width_capped);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
